/* sv/mmcs_pkg.sv */
// shared types and constants for the min-max contrast stretch block
// no dependencies

package mmcs_pkg;

    localparam int PIX_W           = 16;
    localparam int OUT_W           = 8;
    localparam int NUM_W           = PIX_W + OUT_W;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic             OP_MEASURE = 1'b0;
    localparam logic             OP_CONVERT = 1'b1;
    localparam logic [PIX_W-1:0] PIX_MAX    = {PIX_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX    = {OUT_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_ZERO   = '0;

    // one convert job: either a ready result or a divide of diff*255 by span
    typedef struct packed {
        logic             is_div;
        logic [OUT_W-1:0] direct;
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] span;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_port;

endpackage

/* sv/mmcs_front.sv */
// front part: accepts words, tracks running min and max, classifies convert pixels
// depends on mmcs_pkg

module mmcs_front
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,
    input  logic [1:0]       i_s_tuser,
    input  logic             i_q_full,
    output t_job_port        o_push
);

    logic [PIX_W-1:0] r_min, n_min;
    logic [PIX_W-1:0] r_max, n_max;
    logic             w_accept;
    logic             w_op;
    logic             w_first;
    logic [PIX_W-1:0] w_x;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = i_s_tuser[0];
    assign w_first    = i_s_tuser[1];
    assign w_x        = i_s_tdata;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        o_push.valid      = 1'b0;
        o_push.job.is_div = 1'b0;
        o_push.job.direct = OUT_ZERO;
        o_push.job.diff   = w_x - r_min;
        o_push.job.span   = r_max - r_min;

        if (w_accept) begin
            if (w_op == OP_MEASURE) begin
                if (w_first) begin
                    n_min = w_x;
                    n_max = w_x;
                end else begin
                    if (w_x < r_min) n_min = w_x;
                    if (w_x > r_max) n_max = w_x;
                end
            end else begin
                o_push.valid = 1'b1;
                // empty or zero range and pixels below the minimum give zero
                if (r_max <= r_min || w_x < r_min) begin
                    o_push.job.direct = OUT_ZERO;
                end else if (w_x > r_max) begin
                    o_push.job.direct = OUT_MAX;
                end else begin
                    o_push.job.is_div = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= PIX_MAX;
            r_max <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

endmodule

/* sv/mmcs_queue.sv */
// short job queue between front and back parts, held in flops
// depends on mmcs_pkg

module mmcs_queue
    import mmcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_port i_push,
    input  logic      i_pop,
    output t_job_port o_head,
    output logic      o_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

/* sv/mmcs_back.sv */
// back part: serial restoring divider with rounding, and the output register
// depends on mmcs_pkg

module mmcs_back
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job_port        i_head,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(OUT_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [PIX_W-1:0] r_rem, n_rem;
    logic [PIX_W-1:0] r_div, n_div;
    logic [OUT_W-1:0] r_low, n_low;
    logic [OUT_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    logic             w_out_free;
    logic [NUM_W-1:0] w_num;
    logic [PIX_W:0]   w_trial;
    logic             w_ge;
    logic             w_round;
    logic [OUT_W:0]   w_q_rnd;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign w_out_free = !r_out_valid || i_m_tready;

    // diff*255 as diff*256 - diff
    assign w_num   = {i_head.job.diff, OUT_ZERO} - {{OUT_W{1'b0}}, i_head.job.diff};
    assign w_trial = {r_rem, r_low[OUT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    // round half up: remainder at least half the divisor
    assign w_round = ({r_rem, 1'b0} >= {1'b0, r_div});
    assign w_q_rnd = {1'b0, r_quo} + {{OUT_W{1'b0}}, w_round};

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_div       = r_div;
        n_low       = r_low;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (!i_head.job.is_div) begin
                        if (w_out_free) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = i_head.job.direct;
                        end
                    end else begin
                        // numerator < 256*span, so the upper bits start below the divisor
                        o_pop   = 1'b1;
                        n_rem   = w_num[NUM_W-1:OUT_W];
                        n_low   = w_num[OUT_W-1:0];
                        n_div   = i_head.job.span;
                        n_quo   = '0;
                        n_cnt   = CNT_W'(OUT_W - 1);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = w_ge ? PIX_W'(w_trial - {1'b0, r_div}) : w_trial[PIX_W-1:0];
                n_quo = {r_quo[OUT_W-2:0], w_ge};
                n_low = {r_low[OUT_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_q_rnd[OUT_W] ? OUT_MAX : w_q_rnd[OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_low      <= n_low;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

/* sv/minmax_contrast_stretch_16to8.sv */
// channel   dir  signals                           word
// s         in   i_s_tvalid o_s_tready i_s_tdata   tdata: pixel_in; tuser: opcode, first_pixel
//                i_s_tuser
// m         out  o_m_tvalid i_m_tready o_m_tdata   tdata: pixel_out
//
// measure words only update the running min and max in the front part and give no output word
// convert words go through the job queue; out-of-range and empty-range pixels
// give a result in the cycle after the back part picks them up
// in-range pixels go through these steps in the back part: load, 8 steps of the
// serial restoring divider, round; the divider sets the sustained rate
// reset is synchronous, active low; the input stalls only while the queue is full,
// the back part stalls only on its output register

module minmax_contrast_stretch_16to8
    import mmcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH  // 2 to 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,   // [15:0] pixel_in
    input  logic [1:0]       i_s_tuser,   // [0] opcode, [1] first_pixel
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // [7:0] pixel_out
);

    t_job_port w_push;
    t_job_port w_head;
    logic      w_full;
    logic      w_pop;

    mmcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    mmcs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    mmcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* sv/mmcs_checker.sv */
// port-level checks for the contrast stretch block, bound to the top level
// depends on mmcs_pkg

module mmcs_checker
    import mmcs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic [1:0]       i_s_tuser,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // right after reset the queue is empty and no result is pending
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_s_tready && !o_m_tvalid)
        else $error("block not clear after reset");

    // the queue fills only when a convert word is taken
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(i_s_tvalid && i_s_tuser[0] == OP_CONVERT))
        else $error("input stalled without a convert word");

endmodule

bind minmax_contrast_stretch_16to8 mmcs_checker u_mmcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* verif/stretch_checker.sv */
// checker for the min-max contrast stretch block: watches both stream channels,
// tracks the measured range and compares every output word with its prediction
// depends on mmcs_pkg for widths and opcodes
`timescale 1ns / 1ps

module stretch_checker
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,   // [15:0] pixel_in
    input  logic [1:0]       i_s_tuser,   // [0] opcode, [1] first_pixel
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // [7:0] pixel_out
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    logic [PIX_W-1:0] lo_seen;
    logic [PIX_W-1:0] hi_seen;
    logic [OUT_W-1:0] stretched_q[$];
    logic [OUT_W-1:0] want;
    logic             in_op;
    logic             in_first;
    int               errors  = 0;
    int               pending = 0;
    int               checked = 0;

    assign o_errors  = errors;
    assign o_pending = pending;
    assign o_checked = checked;

    function automatic logic [OUT_W-1:0] expected_stretch(
        logic [PIX_W-1:0] x, logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
        logic [31:0] span;
        logic [31:0] scaled;
        logic [31:0] quo;
        // empty or inverted range maps everything to zero
        if (hi <= lo || x < lo) return OUT_ZERO;
        if (x > hi) return OUT_MAX;
        span   = 32'(hi) - 32'(lo);
        scaled = (32'(x) - 32'(lo)) * 32'd255;
        // round half up, done exactly
        quo = (2 * scaled + span) / (2 * span);
        return (quo > 32'(OUT_MAX)) ? OUT_MAX : quo[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lo_seen = PIX_MAX;
            hi_seen = '0;
            stretched_q.delete();
        end else begin
            // output side first: a word leaving now never belongs to one entering now
            if (i_m_tvalid && i_m_tready) begin
                if (stretched_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel_out word, expected none, got %0d",
                             $time, i_m_tdata);
                end else begin
                    want = stretched_q.pop_front();
                    checked++;
                    if (i_m_tdata !== want) begin
                        errors++;
                        $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                                 $time, want, i_m_tdata);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_op    = i_s_tuser[0];
                in_first = i_s_tuser[1];
                if (in_op == OP_MEASURE) begin
                    if (in_first) begin
                        lo_seen = i_s_tdata;
                        hi_seen = i_s_tdata;
                    end else begin
                        // both bounds can move on one word
                        if (i_s_tdata < lo_seen) lo_seen = i_s_tdata;
                        if (i_s_tdata > hi_seen) hi_seen = i_s_tdata;
                    end
                end else begin
                    stretched_q.push_back(expected_stretch(i_s_tdata, lo_seen, hi_seen));
                end
            end
        end
        pending = stretched_q.size();
    end

endmodule

/* verif/tb_minmax_contrast_stretch_16to8.sv */
// top of the min-max contrast stretch testbench: clock, reset, frame stimulus,
// output back-pressure and the final verdict
// depends on mmcs_pkg, minmax_contrast_stretch_16to8 and stretch_checker
`timescale 1ns / 1ps

module tb_minmax_contrast_stretch_16to8
    import mmcs_pkg::*;
();

    localparam int NUM_WORDS    = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 30;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata  = '0;
    logic [1:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int errors;
    int pending;
    int checked;

    int measure_words = 0;
    int convert_words = 0;
    int frames        = 0;
    bit no_gaps       = 1'b0;

    int hold_reqs   = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int steady_left = 0;
    int cycles      = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    minmax_contrast_stretch_16to8 DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    stretch_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // receiver: long hold-off on request, otherwise random stalls and steady stretches
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done < hold_reqs) begin
            holds_done++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (steady_left > 0) begin
            steady_left--;
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0: steady_left = $urandom_range(20, 200);
                1: stall_left = $urandom_range(10, 40);
                2, 3, 4, 5: stall_left = $urandom_range(1, 3);
                default: ;
            endcase
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(logic op, logic [PIX_W-1:0] pix, logic first);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= {first, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_CONVERT) convert_words++;
        else measure_words++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial begin
        int               lo;
        int               hi;
        int               a;
        int               b;
        int               n_meas;
        int               n_conv;
        int               r;
        bit               skip_first;
        logic [PIX_W-1:0] pix;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing measured yet, first flag on a convert word is ignored
        send_word(OP_CONVERT, 16'd0, 1'b0);
        send_word(OP_CONVERT, PIX_MAX, 1'b1);
        // no first flag after reset: one word lowers min and raises max together
        send_word(OP_MEASURE, 16'd1000, 1'b0);
        send_word(OP_CONVERT, 16'd1000, 1'b0);
        send_word(OP_CONVERT, 16'd999, 1'b0);
        send_word(OP_CONVERT, 16'd1001, 1'b0);
        // full range
        send_word(OP_MEASURE, PIX_MAX, 1'b1);
        send_word(OP_MEASURE, 16'd0, 1'b0);
        send_word(OP_CONVERT, 16'd0, 1'b0);
        send_word(OP_CONVERT, PIX_MAX, 1'b0);
        send_word(OP_CONVERT, 16'h8000, 1'b0);
        send_word(OP_CONVERT, 16'h5555, 1'b0);
        send_word(OP_CONVERT, 16'hAAAA, 1'b0);
        // span of two: the midpoint is an exact half
        send_word(OP_MEASURE, 16'd1, 1'b1);
        send_word(OP_MEASURE, 16'd3, 1'b0);
        send_word(OP_CONVERT, 16'd2, 1'b0);
        send_word(OP_CONVERT, 16'd0, 1'b0);
        send_word(OP_CONVERT, 16'd4, 1'b0);
        // below and above the measured window
        send_word(OP_MEASURE, 16'd100, 1'b1);
        send_word(OP_MEASURE, 16'd200, 1'b0);
        send_word(OP_CONVERT, 16'd150, 1'b1);
        send_word(OP_CONVERT, 16'd50, 1'b0);
        send_word(OP_CONVERT, 16'd250, 1'b0);
        wait_drained();

        while (measure_words + convert_words < NUM_WORDS) begin
            frames++;
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    lo = 0;
                    hi = int'(PIX_MAX);
                end
                1: begin
                    lo = $urandom_range(0, 65531);
                    hi = lo + $urandom_range(0, 4);
                end
                default: begin
                    a  = $urandom_range(0, 65535);
                    b  = $urandom_range(0, 65535);
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
            endcase

            // measure pass: window ends come first and last
            skip_first = ($urandom_range(0, 15) == 0);
            n_meas     = $urandom_range(2, 8);
            for (int i = 0; i < n_meas; i++) begin
                if (i == 0) pix = lo[PIX_W-1:0];
                else if (i == n_meas - 1) pix = hi[PIX_W-1:0];
                else pix = 16'($urandom_range(hi, lo));
                send_word(OP_MEASURE, pix, (i == 0) && !skip_first);
            end

            // convert pass; a couple of frames run against a long output hold-off
            n_conv = $urandom_range(4, 20);
            if (frames == 5 || frames == 30) begin
                hold_reqs++;
                no_gaps = 1'b1;
                n_conv  = 24;
            end
            for (int i = 0; i < n_conv; i++) begin
                r = $urandom_range(0, 9);
                if (r < 7) pix = 16'($urandom_range(hi, lo));
                else if (r == 7) pix = (lo == 0) ? 16'd0 : 16'($urandom_range(0, lo - 1));
                else if (r == 8) pix = (hi == PIX_MAX) ? PIX_MAX : 16'($urandom_range(hi + 1, 65535));
                else pix = 16'($urandom);
                send_word(OP_CONVERT, pix, $urandom_range(0, 7) == 0);
            end

            // stray words between frames
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom), 16'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames: %0d measure words, %0d convert words",
                 frames, measure_words, convert_words);
        $display("%0d stretched words compared, %0d failures", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/mmcs_pkg.sv
sv/mmcs_front.sv
sv/mmcs_queue.sv
sv/mmcs_back.sv
sv/minmax_contrast_stretch_16to8.sv
sv/mmcs_checker.sv
verif/stretch_checker.sv
verif/tb_minmax_contrast_stretch_16to8.sv
